### rtl/brd_pkg.sv
// Shared types and constants for the base relocation decoder.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package brd_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COUNT_W = 31;

  localparam logic [15:0]        OFFSET_MASK  = 16'h0FFF;
  localparam int unsigned        TYPE_SHIFT   = 12;
  localparam logic [3:0]         TYPE_HIGHLOW = 4'd3;
  localparam logic [31:0]        HEADER_BYTES = 32'd8;
  localparam logic [31:0]        BYTES_MAX    = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_ADDRESS = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // One directory byte held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       start_of_directory;
  } in_item_t;

  // One result word on its way to the output register.
  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] total;
  } result_t;

endpackage

`default_nettype wire

### rtl/brd_ifs.sv
// Channel interfaces of the base relocation decoder: input bytes, results
// and the directory size write port. Depends on brd_pkg for field widths.
`default_nettype none

interface brd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_directory;

  modport source (output valid, output data_byte, output start_of_directory, input ready);
  modport sink   (input valid, input data_byte, input start_of_directory, output ready);
endinterface

interface brd_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  result_kind;
  logic [brd_pkg::ADDR_W-1:0]  reloc_address;
  logic [brd_pkg::COUNT_W-1:0] reloc_total;

  modport source (output valid, output result_kind, output reloc_address,
                  output reloc_total, input ready);
  modport sink   (input valid, input result_kind, input reloc_address,
                  input reloc_total, output ready);
endinterface

interface brd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] directory_size;

  modport source (output valid, output directory_size, input ready);
  modport sink   (input valid, input directory_size, output ready);
endinterface

`default_nettype wire

### rtl/base_relocation_decoder.sv
// Top level of the base relocation decoder: input register, parser and
// output register. Depends on brd_pkg, brd_ifs and the three stage modules.
//
// Usage:
//   in_ch carries the relocation directory one byte word at a time, little
//   endian; start_of_directory marks the first byte of a new directory and
//   clears all parse state. out_ch carries result words: a relocation
//   address, a directory done word with the address count, or an error for a
//   block size below eight. cfg_ch writes the directory size in bytes; it is
//   always ready and is meant to be written while the block is idle.
//   Throughput is one byte per cycle while the output register is free: the
//   parse step is a single pass of header assembly, a 32-bit add and compares
//   between the input register and the output register, and its result word
//   is registered in the output register. Most bytes give no result word.
//   When the receiver stalls, the output register holds its word and the
//   input register keeps accepting until it holds a byte that cannot move.
//   A synchronous reset clears the parse state, both registers and the
//   directory size.
`default_nettype none

module base_relocation_decoder (
  input wire logic  clk,
  input wire logic  rst_n,
  brd_in_if.sink    in_ch,
  brd_out_if.source out_ch,
  brd_cfg_if.sink   cfg_ch
);

  logic [31:0]       directory_size_r;
  brd_pkg::in_item_t item;
  brd_pkg::result_t  res;
  logic              take;
  logic              out_free;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      directory_size_r <= '0;
    end else if (cfg_ch.valid) begin
      directory_size_r <= cfg_ch.directory_size;
    end
  end

  brd_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_data_byte (in_ch.data_byte),
    .in_start     (in_ch.start_of_directory),
    .take         (take),
    .item         (item)
  );

  brd_parse_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .directory_size (directory_size_r),
    .item           (item),
    .out_free       (out_free),
    .take           (take),
    .res            (res)
  );

  brd_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .res         (res),
    .take        (take),
    .out_free    (out_free),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_kind    (out_ch.result_kind),
    .out_address (out_ch.reloc_address),
    .out_total   (out_ch.reloc_total)
  );

endmodule

`default_nettype wire

### rtl/brd_in_stage.sv
// Input register of the base relocation decoder: holds one byte word until
// the parser takes it. Depends on brd_pkg.
`default_nettype none

module brd_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_start,
  input  wire logic              take,
  output brd_pkg::in_item_t      item
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       start_r;

  // The register refills in the same cycle in which the parser drains it.
  assign in_ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r  <= in_data_byte;
      start_r <= in_start;
    end
  end

  assign item = '{valid: valid_r, data_byte: byte_r, start_of_directory: start_r};

endmodule

`default_nettype wire

### rtl/brd_parse_core.sv
// Parse state of the base relocation decoder and the per-byte step logic:
// header assembly, entry decode, block end and directory done checks.
// Depends on brd_pkg.
`default_nettype none

module brd_parse_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [31:0]       directory_size,
  input  brd_pkg::in_item_t      item,
  input  wire logic              out_free,
  output logic                   take,
  output brd_pkg::result_t       res
);

  logic [31:0]                 bytes_consumed_r, bytes_consumed_nxt;
  logic [31:0]                 block_position_r, block_position_nxt;
  logic [31:0]                 page_address_r, page_address_nxt;
  logic [31:0]                 block_length_r, block_length_nxt;
  logic [7:0]                  entry_low_r, entry_low_nxt;
  logic [brd_pkg::COUNT_W-1:0] emitted_r, emitted_nxt;
  logic                        halted_r, halted_nxt;

  // State as seen by this byte, after a start marker has cleared it.
  logic [31:0]                 bc, pos, page, len;
  logic [7:0]                  low;
  logic [brd_pkg::COUNT_W-1:0] cnt;
  logic                        halt;

  logic [7:0]  b;
  logic [15:0] entry;
  logic [3:0]  entry_type;
  logic [31:0] addr;
  logic        have_addr;
  logic        stop;

  assign take = item.valid && out_free;
  assign b    = item.data_byte;

  always_comb begin
    bc   = item.start_of_directory ? '0   : bytes_consumed_r;
    pos  = item.start_of_directory ? '0   : block_position_r;
    page = item.start_of_directory ? '0   : page_address_r;
    len  = item.start_of_directory ? '0   : block_length_r;
    low  = item.start_of_directory ? '0   : entry_low_r;
    cnt  = item.start_of_directory ? '0   : emitted_r;
    halt = item.start_of_directory ? 1'b0 : halted_r;

    bytes_consumed_nxt = bc;
    block_position_nxt = pos;
    page_address_nxt   = page;
    block_length_nxt   = len;
    entry_low_nxt      = low;
    emitted_nxt        = cnt;
    halted_nxt         = halt;

    entry      = {b, low};
    entry_type = 4'(entry >> brd_pkg::TYPE_SHIFT);
    addr       = page + {16'd0, entry & brd_pkg::OFFSET_MASK};
    have_addr  = 1'b0;
    stop       = 1'b0;

    res.valid   = 1'b0;
    res.kind    = brd_pkg::KIND_ADDRESS;
    res.address = '0;

    // Bytes at a block boundary past the directory size are dropped.
    if (!halt && !(pos == '0 && bc >= directory_size)) begin
      if (bc != brd_pkg::BYTES_MAX) begin
        bytes_consumed_nxt = bc + 32'd1;
      end

      if (pos < 32'd4) begin
        if (pos == '0) begin
          page_address_nxt = '0;
        end
        page_address_nxt[{pos[1:0], 3'b000} +: 8] = b;
      end else if (pos < brd_pkg::HEADER_BYTES) begin
        if (pos == 32'd4) begin
          block_length_nxt = '0;
        end
        block_length_nxt[{pos[1:0], 3'b000} +: 8] = b;
        if (pos == brd_pkg::HEADER_BYTES - 32'd1 &&
            block_length_nxt < brd_pkg::HEADER_BYTES) begin
          halted_nxt         = 1'b1;
          block_position_nxt = '0;
          res.valid          = 1'b1;
          res.kind           = brd_pkg::KIND_ERROR;
          stop               = 1'b1;
        end
      end else if (!pos[0]) begin
        entry_low_nxt = b;
      end else if (entry_type == brd_pkg::TYPE_HIGHLOW) begin
        have_addr = 1'b1;
        if (cnt != brd_pkg::COUNT_MAX) begin
          emitted_nxt = cnt + 1'b1;
        end
      end

      if (!stop) begin
        if (pos >= brd_pkg::HEADER_BYTES - 32'd1 && pos == block_length_nxt - 32'd1) begin
          block_position_nxt = '0;
          if (bytes_consumed_nxt >= directory_size) begin
            // A done word also carries the address of an entry that ends it.
            res.valid   = 1'b1;
            res.kind    = brd_pkg::KIND_DONE;
            res.address = have_addr ? addr : '0;
          end
        end else begin
          block_position_nxt = pos + 32'd1;
        end
        if (have_addr && !res.valid) begin
          res.valid   = 1'b1;
          res.kind    = brd_pkg::KIND_ADDRESS;
          res.address = addr;
        end
      end
    end

    res.total = emitted_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_consumed_r <= '0;
      block_position_r <= '0;
      page_address_r   <= '0;
      block_length_r   <= '0;
      entry_low_r      <= '0;
      emitted_r        <= '0;
      halted_r         <= 1'b0;
    end else if (take) begin
      bytes_consumed_r <= bytes_consumed_nxt;
      block_position_r <= block_position_nxt;
      page_address_r   <= page_address_nxt;
      block_length_r   <= block_length_nxt;
      entry_low_r      <= entry_low_nxt;
      emitted_r        <= emitted_nxt;
      halted_r         <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/brd_out_stage.sv
// Output register of the base relocation decoder: holds one result word
// until the receiver takes it. Depends on brd_pkg.
`default_nettype none

module brd_out_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  brd_pkg::result_t                 res,
  input  wire logic                        take,
  output logic                             out_free,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_kind,
  output logic [brd_pkg::ADDR_W-1:0]       out_address,
  output logic [brd_pkg::COUNT_W-1:0]      out_total
);

  logic                        valid_r;
  brd_pkg::kind_t              kind_r;
  logic [brd_pkg::ADDR_W-1:0]  address_r;
  logic [brd_pkg::COUNT_W-1:0] total_r;
  logic                        load;

  assign out_free = !valid_r || out_ready;
  assign load     = take && res.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r    <= res.kind;
      address_r <= res.address;
      total_r   <= res.total;
    end
  end

  assign out_valid   = valid_r;
  assign out_kind    = kind_r;
  assign out_address = address_r;
  assign out_total   = total_r;

endmodule

`default_nettype wire

### rtl/brd_checker.sv
// Port-level checks for the base relocation decoder, attached to the top
// level by the bind below. Depends on brd_pkg for widths and result codes.
`default_nettype none

module brd_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [1:0]                  out_kind,
  input wire logic [brd_pkg::ADDR_W-1:0]  out_address,
  input wire logic [brd_pkg::COUNT_W-1:0] out_total
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_address) && $stable(out_total))
    else $error("result word changed while stalled");

  // An error word never carries an address.
  a_error_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == brd_pkg::KIND_ERROR |-> out_address == '0)
    else $error("error word with nonzero address");

  // With the output register empty, the input side never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // Reset empties the output register.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind base_relocation_decoder brd_checker u_brd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_kind    (out_ch.result_kind),
  .out_address (out_ch.reloc_address),
  .out_total   (out_ch.reloc_total)
);

`default_nettype wire

### tb/tb_base_relocation_decoder.sv
`timescale 1ns / 100ps
// Testbench for base_relocation_decoder: streams relocation directories byte by byte
// and checks every result word against a cycle-free decoder kept in the bench.
// Depends on brd_pkg, the brd_*_if interfaces and the decoder RTL.

module tb_base_relocation_decoder;

  localparam int RANDOM_BYTES  = 1400;
  localparam int QUIET_AFTER   = 1100;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int DRAIN_CYCLES  = 6;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    brd_pkg::kind_t              kind;
    logic [brd_pkg::ADDR_W-1:0]  addr;
    logic [brd_pkg::COUNT_W-1:0] total;
  } reloc_word_t;

  logic clk;
  logic rst_n;

  brd_in_if  in_ch();
  brd_out_if out_ch();
  brd_cfg_if cfg_ch();

  base_relocation_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decoder state mirrored in the bench.
  logic [31:0]                 limit_bytes;
  logic [31:0]                 consumed;
  logic [31:0]                 blk_pos;
  logic [31:0]                 page_addr;
  logic [31:0]                 blk_len;
  logic [7:0]                  entry_lo;
  logic [brd_pkg::COUNT_W-1:0] addr_count;
  logic                        halted;

  reloc_word_t pending_words[$];
  logic [7:0]  dir_bytes[$];

  int  mismatches;
  int  bytes_sent;
  int  directories;
  int  words_checked;
  int  done_words;
  int  error_words;
  int  idle_cycles;
  int  stall_left;
  bit  quiet;

  function automatic void clear_walk();
    consumed   = '0;
    blk_pos    = '0;
    page_addr  = '0;
    blk_len    = '0;
    entry_lo   = '0;
    addr_count = '0;
    halted     = 1'b0;
  endfunction

  function automatic void queue_word(input brd_pkg::kind_t kind, input logic [31:0] addr);
    reloc_word_t w;
    w.kind  = kind;
    w.addr  = addr;
    w.total = addr_count;
    pending_words.push_back(w);
  endfunction

  // Advances the mirrored state by one accepted byte and queues any result it causes.
  function automatic void decode_byte(input logic [7:0] b, input logic sod);
    logic [31:0] pos;
    logic [15:0] entry;
    logic [31:0] addr;
    logic        hit;
    hit  = 1'b0;
    addr = '0;
    if (sod) clear_walk();
    if (halted) return;
    if (blk_pos == 0 && consumed >= limit_bytes) return;
    pos = blk_pos;
    if (consumed != brd_pkg::BYTES_MAX) consumed = consumed + 32'd1;
    if (pos < 4) begin
      if (pos == 0) page_addr = '0;
      page_addr = page_addr | ({24'd0, b} << (8 * pos));
    end else if (pos < brd_pkg::HEADER_BYTES) begin
      if (pos == 4) blk_len = '0;
      blk_len = blk_len | ({24'd0, b} << (8 * (pos - 4)));
      if (pos == brd_pkg::HEADER_BYTES - 1 && blk_len < brd_pkg::HEADER_BYTES) begin
        halted  = 1'b1;
        blk_pos = '0;
        queue_word(brd_pkg::KIND_ERROR, '0);
        return;
      end
    end else if (!pos[0]) begin
      entry_lo = b;
    end else begin
      entry = {b, entry_lo};
      if (entry[15:brd_pkg::TYPE_SHIFT] == brd_pkg::TYPE_HIGHLOW) begin
        addr = page_addr + {16'd0, entry & brd_pkg::OFFSET_MASK};
        hit  = 1'b1;
        if (addr_count != brd_pkg::COUNT_MAX) addr_count = addr_count + 1'b1;
      end
    end
    if (pos >= brd_pkg::HEADER_BYTES - 1 && pos == blk_len - 32'd1) begin
      blk_pos = '0;
      if (consumed >= limit_bytes) begin
        queue_word(brd_pkg::KIND_DONE, hit ? addr : 32'd0);
        return;
      end
    end else begin
      blk_pos = pos + 1;
    end
    if (hit) queue_word(brd_pkg::KIND_ADDRESS, addr);
  endfunction

  function automatic void flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("mismatch at %0t ns: %s", $time, what);
  endfunction

  function automatic void add_u16(input logic [15:0] v);
    dir_bytes.push_back(v[7:0]);
    dir_bytes.push_back(v[15:8]);
  endfunction

  function automatic void add_u32(input logic [31:0] v);
    add_u16(v[15:0]);
    add_u16(v[31:16]);
  endfunction

  // Driver tasks are entered and left just after a falling edge.
  task automatic push_byte(input logic [7:0] b, input logic sod);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid              <= 1'b1;
    in_ch.data_byte          <= b;
    in_ch.start_of_directory <= sod;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_byte(b, sod);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Waits until the decoder has delivered every word and has nothing left in flight.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_dir_size(input logic [31:0] value);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.directory_size <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    limit_bytes = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_directory(input logic [31:0] size_cfg);
    settle();
    write_dir_size(size_cfg);
    for (int i = 0; i < dir_bytes.size(); i++) push_byte(dir_bytes[i], i == 0);
    dir_bytes.delete();
    directories++;
  endtask

  // The size register still holds its reset value of zero, so every byte is dropped.
  task automatic test_empty_directory();
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'($urandom_range(0, 255)), 1'b0);
    push_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Padding, an unknown type, an address that wraps past 32 bits, offset zero,
  // and a last entry that also closes the directory.
  task automatic test_highlow_entries();
    add_u32(32'hFFFF_F800);
    add_u32(32'd16);
    add_u16(16'h0000);
    add_u16(16'h3FFF);
    add_u16(16'hA123);
    add_u16(16'h3000);
    send_directory(32'd16);
  endtask

  // A block size of seven halts the walk; the byte after it is dropped.
  task automatic test_short_block();
    add_u32($urandom);
    add_u32(32'd7);
    dir_bytes.push_back(8'h5A);
    send_directory(32'd64);
  endtask

  // A header-only block, then an odd-sized block whose spare byte ends the directory.
  task automatic test_odd_block();
    add_u32(32'h0040_1000);
    add_u32(32'd8);
    add_u32(32'h8000_0000);
    add_u32(32'd11);
    add_u16(16'h3123);
    dir_bytes.push_back(8'hFF);
    dir_bytes.push_back(8'hC3);
    send_directory(32'd19);
  endtask

  task automatic test_random_directories();
    int          first_byte;
    int          nblk;
    int          pick;
    logic [31:0] span;
    logic [31:0] size_cfg;
    logic [31:0] page;
    logic [31:0] blen;
    logic [3:0]  typ;
    logic [11:0] ofs;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < RANDOM_BYTES) begin
      if (bytes_sent - first_byte >= QUIET_AFTER) quiet = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        // Unstructured bytes with stray start markers.
        settle();
        write_dir_size($urandom_range(0, 64));
        repeat ($urandom_range(4, 40))
          push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        continue;
      end
      span = '0;
      nblk = $urandom_range(1, 4);
      for (int n = 0; n < nblk; n++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)      blen = $urandom_range(0, 7);
        else if (pick < 3)  blen = 32'd8;
        else if (pick == 3) blen = 32'd8 + $urandom_range(100, 200);
        else                blen = 32'd8 + $urandom_range(0, 24);
        if ($urandom_range(0, 3) == 0) page = 32'hFFFF_F000 | $urandom_range(0, 4095);
        else                           page = $urandom;
        add_u32(page);
        add_u32(blen);
        if (blen < brd_pkg::HEADER_BYTES) begin
          span = span + brd_pkg::HEADER_BYTES;
          break;
        end
        for (logic [31:0] k = brd_pkg::HEADER_BYTES; k + 1 < blen; k = k + 2) begin
          typ = ($urandom_range(0, 9) < 6) ? brd_pkg::TYPE_HIGHLOW
                                           : 4'($urandom_range(0, 15));
          pick = $urandom_range(0, 9);
          ofs = (pick == 0) ? 12'h000 : (pick == 1) ? 12'hFFF : 12'($urandom_range(0, 4095));
          add_u16({typ, ofs});
        end
        if (blen[0]) dir_bytes.push_back(8'($urandom_range(0, 255)));
        span = span + blen;
      end
      pick = $urandom_range(0, 19);
      if (pick < 12)      size_cfg = span;
      else if (pick < 15) size_cfg = span - $urandom_range(1, 8);
      else if (pick < 17) size_cfg = span + $urandom_range(1, 16);
      else if (pick == 17) size_cfg = '0;
      else if (pick == 18) size_cfg = 32'hFFFF_FFFF;
      else                size_cfg = $urandom_range(1, span);
      repeat ($urandom_range(0, 3)) dir_bytes.push_back(8'($urandom_range(0, 255)));
      send_directory(size_cfg);
    end
  endtask

  // Result side: random stall bursts, none once the run goes quiet.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left   <= $urandom_range(0, 7);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_word
    reloc_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected word kind %0d addr %h total %0d",
                                out_ch.result_kind, out_ch.reloc_address,
                                out_ch.reloc_total));
      end else begin
        w = pending_words.pop_front();
        words_checked++;
        if (w.kind == brd_pkg::KIND_DONE)  done_words++;
        if (w.kind == brd_pkg::KIND_ERROR) error_words++;
        if (out_ch.result_kind != w.kind)
          flag_mismatch($sformatf("kind expected %0d got %0d", w.kind, out_ch.result_kind));
        if (out_ch.reloc_address != w.addr)
          flag_mismatch($sformatf("address expected %h got %h", w.addr, out_ch.reloc_address));
        if (out_ch.reloc_total != w.total)
          flag_mismatch($sformatf("total expected %0d got %0d", w.total, out_ch.reloc_total));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_MAX) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_MAX);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    clk                      = 1'b0;
    rst_n                    = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.data_byte          = '0;
    in_ch.start_of_directory = 1'b0;
    out_ch.ready             = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.directory_size    = '0;
    stall_left               = 0;
    idle_cycles              = 0;
    quiet                    = 1'b0;
    mismatches               = 0;
    bytes_sent               = 0;
    directories              = 0;
    words_checked            = 0;
    done_words               = 0;
    error_words              = 0;
    limit_bytes              = '0;
    clear_walk();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_directory();
    test_highlow_entries();
    test_short_block();
    test_odd_block();
    test_random_directories();

    quiet = 1'b1;
    settle();
    if (pending_words.size() != 0)
      flag_mismatch($sformatf("%0d words never arrived", pending_words.size()));

    $display("Streamed %0d bytes over %0d directories, size register set each time.",
             bytes_sent, directories);
    $display("Checked %0d result words: %0d done, %0d short-block errors, %0d mismatches.",
             words_checked, done_words, error_words, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
